### rtl/core/battery_gauge_monitor_macros.svh
// Assertion macros for the battery gauge monitor.
// Used by the top level only; no other dependencies.
`ifndef BATTERY_GAUGE_MONITOR_MACROS_SVH
`define BATTERY_GAUGE_MONITOR_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BGM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define BGM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### rtl/core/bgm_pkg.sv
// Shared constants and types for the battery gauge monitor.
// No dependencies.
package bgm_pkg;
    localparam int ADC_BITS_DEF  = 10;
    localparam int MEAN_FRAC_DEF = 8;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_FRAC     = 10;
    localparam int MV_BITS       = 15;
    localparam int PCT_BITS      = 7;
    localparam logic [MV_BITS-1:0] PACK_MAX = 15'd20000;
    localparam logic [PCT_BITS-1:0] PCT_MAX = 7'd99;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd19955;

    localparam logic REG_CHEMISTRY = 1'b0;
    localparam logic REG_GAIN      = 1'b1;

    typedef enum logic [1:0] {
        COL_GREEN  = 2'd0,
        COL_ORANGE = 2'd1,
        COL_RED    = 2'd2,
        COL_BLACK  = 2'd3
    } color_t;

    // Interpolation segment: lower knee voltage, span, base pct, pct rise.
    typedef struct packed {
        logic        hit;
        logic [13:0] v_lo;
        logic [10:0] span;
        logic [6:0]  c_lo;
        logic [6:0]  rise;
    } seg_t;

    function automatic seg_t find_seg(input logic chem, input logic [14:0] v);
        seg_t s;
        s = '0;
        if (!chem) begin
            if (v >= 15'd4000)      s = '{1'b1, 14'd4000, 11'd200, 7'd90, 7'd10};
            else if (v >= 15'd3850) s = '{1'b1, 14'd3850, 11'd150, 7'd75, 7'd15};
            else if (v >= 15'd3750) s = '{1'b1, 14'd3750, 11'd100, 7'd50, 7'd25};
            else if (v >= 15'd3550) s = '{1'b1, 14'd3550, 11'd200, 7'd7,  7'd43};
            else if (v >= 15'd3350) s = '{1'b1, 14'd3350, 11'd200, 7'd0,  7'd7};
        end else begin
            if (v >= 15'd12847)      s = '{1'b1, 14'd12847, 11'd1105, 7'd75, 7'd25};
            else if (v >= 15'd12733) s = '{1'b1, 14'd12733, 11'd114,  7'd50, 7'd25};
            else if (v >= 15'd12455) s = '{1'b1, 14'd12455, 11'd278,  7'd20, 7'd30};
            else if (v >= 15'd12169) s = '{1'b1, 14'd12169, 11'd286,  7'd10, 7'd10};
            else if (v >= 15'd11755) s = '{1'b1, 14'd11755, 11'd414,  7'd5,  7'd5};
            else if (v >= 15'd10424) s = '{1'b1, 14'd10424, 11'd1331, 7'd0,  7'd5};
        end
        return s;
    endfunction
endpackage

### rtl/core/bgm_stream_if.sv
// Valid/ready channel interfaces for the battery gauge monitor.
// Depends on nothing but its parameters.
interface bgm_in_if #(parameter int ADC_BITS = 10);
    logic                valid;
    logic                ready;
    logic                mode;
    logic [ADC_BITS-1:0] adc_sample;
    logic [1:0]          forced_color;
    modport source (output valid, mode, adc_sample, forced_color, input ready);
    modport sink   (input valid, mode, adc_sample, forced_color, output ready);
endinterface

interface bgm_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] pack_mv;
    logic [2:0]  cells;
    logic [14:0] per_cell_mv;
    logic [6:0]  charge_pct;
    logic [1:0]  color;
    modport source (output valid, pack_mv, cells, per_cell_mv, charge_pct, color,
                    input ready);
    modport sink   (input valid, pack_mv, cells, per_cell_mv, charge_pct, color,
                    output ready);
endinterface

interface bgm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/bgm_serial_arith.sv
// Shared bit-serial unit: shift-add multiply and restoring divide.
// Depends on nothing; operand width set by parameter.
module bgm_serial_arith #(
    parameter int W = 34
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         is_div,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] result
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_next;
    logic [W-1:0] sh_reg;
    logic [W-1:0] sh_next;
    logic [W-1:0] op_reg;
    logic         div_reg;
    logic [CW-1:0] cnt_reg;
    logic         busy_reg;
    logic [W:0]   trial;

    always_comb
    begin
        acc_next = acc_reg;
        sh_next  = sh_reg;
        trial    = '0;
        if (div_reg)
        begin
            // restoring: shift remainder, bring in next dividend bit
            trial   = {acc_reg, sh_reg[W-1]} - {1'b0, op_reg};
            sh_next = {sh_reg[W-2:0], ~trial[W]};
            acc_next = trial[W] ? {acc_reg[W-2:0], sh_reg[W-1]} : trial[W-1:0];
        end
        else
        begin
            if (sh_reg[0])
                acc_next = acc_reg + op_reg;
            sh_next = sh_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // multiply: op shifts left each step; divide: op fixed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            sh_reg  <= b;
            op_reg  <= a;
            div_reg <= is_div;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            sh_reg  <= sh_next;
            if (!div_reg)
                op_reg <= op_reg << 1;
        end
    end

    assign result = div_reg ? sh_reg : acc_reg;
endmodule

### rtl/core/battery_gauge_monitor.sv
// Battery gauge monitor top level: sequencer around one bit-serial unit.
// Depends on bgm_pkg, the channel interfaces, bgm_serial_arith and the macros header.
// One item at a time. A sample beat runs six passes through the shared serial unit:
// average multiply by 19, divide by 20, gain multiply, divide by cells, interpolation
// multiply and interpolation divide. Each pass takes W = ADC_BITS+MEAN_FRAC_BITS+16
// steps plus a handover. A table lookup state and an output state follow, and the
// output register then holds the valid result. The serial unit's width W sets the
// length of each pass. A seeding or forced-colour beat skips the two averaging
// passes. A cell voltage below the table skips the two interpolation passes.
// The result sits in an output register; the next beat is accepted once it is taken.
// Configuration writes are taken whenever offered and must only arrive while idle.
`include "battery_gauge_monitor_macros.svh"
module battery_gauge_monitor #(
    parameter int ADC_BITS       = bgm_pkg::ADC_BITS_DEF,
    parameter int MEAN_FRAC_BITS = bgm_pkg::MEAN_FRAC_DEF
) (
    input logic clk,
    input logic rst_n,
    bgm_in_if.sink     in_ch,
    bgm_out_if.source  out_ch,
    bgm_cfg_if.sink    cfg
);
    localparam int MB = ADC_BITS + MEAN_FRAC_BITS;
    localparam int W  = MB + bgm_pkg::GAIN_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_AVG, S_AVG_DIV, S_GAIN, S_CELL_DIV, S_LOOKUP, S_INT_MUL, S_INT_DIV, S_OUT
    } state_t;

    state_t state_reg;
    logic   chem_reg;
    logic [15:0] gain_reg;
    logic [MB-1:0] mean_reg;
    logic [2:0]  cells_reg;
    logic [1:0]  color_reg;
    logic        mode_reg;
    logic [MB-1:0] samp_reg;
    logic [14:0] pack_reg;
    logic [14:0] per_reg;
    logic [6:0]  pct_reg;
    bgm_pkg::seg_t seg_reg;
    logic        start;
    logic        is_div;
    logic [W-1:0] op_a;
    logic [W-1:0] op_b;
    logic        done;
    logic [W-1:0] res;
    logic [W-1:0] pack_full;
    logic [14:0] pack_sat;
    logic [W-1:0] pct_sum;
    logic [6:0]  pct_clamped;
    bgm_pkg::seg_t seg_now;

    function automatic logic [2:0] cells_of(input logic [14:0] p);
        logic [2:0] c;
        c = (cells_reg == 3'd0) ? 3'd1 : cells_reg;
        if (!mode_reg)
        begin
            if (chem_reg)          c = 3'd1;
            else if (p >= 15'd17000) c = 3'd1;
            else if (p >= 15'd12800) c = 3'd4;
            else if (p >= 15'd9000)  c = 3'd3;
            else if (p >= 15'd6000)  c = 3'd2;
        end
        return c;
    endfunction

    function automatic logic [1:0] next_color(input logic [1:0] c, input logic [6:0] p);
        logic [1:0] n;
        n = c;
        if (p >= 7'd80 && c != bgm_pkg::COL_GREEN)        n = bgm_pkg::COL_GREEN;
        else if (p < 7'd25 && c == bgm_pkg::COL_GREEN)    n = bgm_pkg::COL_ORANGE;
        else if (p < 7'd15 && c == bgm_pkg::COL_ORANGE)   n = bgm_pkg::COL_RED;
        else if (p < 7'd5 && c == bgm_pkg::COL_RED)       n = bgm_pkg::COL_BLACK;
        return n;
    endfunction

    bgm_serial_arith #(.W(W)) u_arith (
        .clk(clk), .rst_n(rst_n), .start(start), .is_div(is_div),
        .a(op_a), .b(op_b), .done(done), .result(res)
    );

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = (state_reg == S_IDLE) && !out_ch.valid;

    assign pack_full = res >> (MEAN_FRAC_BITS + bgm_pkg::GAIN_FRAC);
    assign pack_sat  = (pack_full > W'(bgm_pkg::PACK_MAX)) ? bgm_pkg::PACK_MAX
                                                           : pack_full[14:0];
    assign seg_now   = bgm_pkg::find_seg(chem_reg, per_reg);
    // full-width sum so a large quotient still clamps
    assign pct_sum     = W'(seg_reg.c_lo) + res;
    assign pct_clamped = (pct_sum > W'(bgm_pkg::PCT_MAX)) ? bgm_pkg::PCT_MAX
                                                          : pct_sum[6:0];

    // operand selection for the shared unit, keyed by the current state, for the pass of the state being entered
    always_comb
    begin
        start  = 1'b0;
        is_div = 1'b0;
        op_a   = '0;
        op_b   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid && in_ch.ready && !in_ch.mode && mean_reg != '0)
                begin
                    start = 1'b1;
                    op_a  = W'(mean_reg);
                    op_b  = W'(19);
                end
                else if (in_ch.valid && in_ch.ready)
                begin
                    start = 1'b1;
                    op_a  = W'(in_ch.mode ? mean_reg
                                          : MB'(in_ch.adc_sample) << MEAN_FRAC_BITS);
                    op_b  = W'(gain_reg);
                end
            end
            S_AVG:
            begin
                if (done)
                begin
                    start  = 1'b1;
                    is_div = 1'b1;
                    op_a   = W'(20);
                    op_b   = res + W'(samp_reg);
                end
            end
            S_AVG_DIV:
            begin
                if (done)
                begin
                    start = 1'b1;
                    op_a  = W'(res[MB-1:0]);
                    op_b  = W'(gain_reg);
                end
            end
            S_GAIN:
            begin
                if (done)
                begin
                    start  = 1'b1;
                    is_div = 1'b1;
                    op_a   = W'(cells_of(pack_sat));
                    op_b   = W'(pack_sat);
                end
            end
            S_LOOKUP:
            begin
                if (seg_now.hit)
                begin
                    start = 1'b1;
                    op_a  = W'(seg_now.rise);
                    op_b  = W'(per_reg - 15'(seg_now.v_lo));
                end
            end
            S_INT_MUL:
            begin
                if (done)
                begin
                    start  = 1'b1;
                    is_div = 1'b1;
                    op_a   = W'(seg_reg.span);
                    op_b   = res;
                end
            end
            default:
            begin
                start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            chem_reg     <= 1'b0;
            gain_reg     <= bgm_pkg::GAIN_RESET;
            mean_reg     <= '0;
            cells_reg    <= 3'd1;
            color_reg    <= bgm_pkg::COL_GREEN;
            mode_reg     <= 1'b0;
            samp_reg     <= '0;
            pack_reg     <= '0;
            per_reg      <= '0;
            pct_reg      <= '0;
            seg_reg      <= '0;
            out_ch.valid <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == bgm_pkg::REG_CHEMISTRY) chem_reg <= cfg.data[0];
                else                                     gain_reg <= cfg.data;
            end
            if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        mode_reg <= in_ch.mode;
                        samp_reg <= MB'(in_ch.adc_sample) << MEAN_FRAC_BITS;
                        if (in_ch.mode)
                        begin
                            color_reg <= in_ch.forced_color;
                            state_reg <= S_GAIN;
                        end
                        else if (mean_reg != '0)
                            state_reg <= S_AVG;
                        else
                        begin
                            mean_reg  <= MB'(in_ch.adc_sample) << MEAN_FRAC_BITS;
                            state_reg <= S_GAIN;
                        end
                    end
                end
                S_AVG:      if (done) state_reg <= S_AVG_DIV;
                S_AVG_DIV:
                begin
                    if (done)
                    begin
                        mean_reg  <= res[MB-1:0];
                        state_reg <= S_GAIN;
                    end
                end
                S_GAIN:
                begin
                    if (done)
                    begin
                        pack_reg  <= pack_sat;
                        cells_reg <= cells_of(pack_sat);
                        state_reg <= S_CELL_DIV;
                    end
                end
                S_CELL_DIV:
                begin
                    if (done)
                    begin
                        per_reg   <= res[14:0];
                        // table lookup needs per_reg, so it gets its own state
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    seg_reg <= seg_now;
                    if (seg_now.hit)
                        state_reg <= S_INT_MUL;
                    else
                    begin
                        pct_reg   <= '0;
                        state_reg <= S_OUT;
                    end
                end
                S_INT_MUL:  if (done) state_reg <= S_INT_DIV;
                S_INT_DIV:
                begin
                    if (done)
                    begin
                        pct_reg   <= pct_clamped;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!mode_reg)
                        color_reg <= next_color(color_reg, pct_reg);
                    out_ch.valid <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT)
        begin
            out_ch.pack_mv     <= pack_reg;
            out_ch.cells       <= cells_reg;
            out_ch.per_cell_mv <= per_reg;
            out_ch.charge_pct  <= pct_reg;
            out_ch.color       <= mode_reg ? color_reg : next_color(color_reg, pct_reg);
        end
    end

    `BGM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `BGM_ASSERT_NXT(a_out_after_seq, clk, rst_n, state_reg == S_OUT, out_ch.valid)
    `BGM_ASSERT_IMP(a_cells_range, clk, rst_n, out_ch.valid, out_ch.cells != 3'd0 && out_ch.cells <= 3'd4)
    `BGM_ASSERT_IMP(a_pct_range, clk, rst_n, out_ch.valid, out_ch.charge_pct <= 7'd99)
endmodule

### sim/bgm_tb_ifs.sv
// Gauge tables for the bench's reading predictor.
// No dependencies.
package bgm_tb_pkg;
    localparam int LIPO_N = 6;
    localparam int LFP_N  = 7;
    localparam int unsigned LIPO_MV  [LIPO_N] = '{4200, 4000, 3850, 3750, 3550, 3350};
    localparam int unsigned LIPO_PCT [LIPO_N] = '{100, 90, 75, 50, 7, 0};
    localparam int unsigned LFP_MV   [LFP_N]  =
        '{13952, 12847, 12733, 12455, 12169, 11755, 10424};
    localparam int unsigned LFP_PCT  [LFP_N]  = '{100, 75, 50, 20, 10, 5, 0};
endpackage

### sim/tb.sv
// Self-checking bench for battery_gauge_monitor: random and directed sample and
// forced-colour beats, predicted in-bench and compared field by field.
// Depends on bgm_pkg, bgm_tb_pkg, the channel interfaces and the RTL.
module tb;
    typedef struct packed {
        logic       mode;
        logic [9:0] adc;
        logic [1:0] fcol;
    } beat_t;

    typedef struct packed {
        logic [14:0] pack;
        logic [2:0]  cells;
        logic [14:0] per_cell;
        logic [6:0]  pct;
        logic [1:0]  color;
    } gauge_t;

    logic clk;
    logic rst_n;

    bgm_in_if  #(.ADC_BITS(10)) in_ch ();
    bgm_out_if out_ch ();
    bgm_cfg_if cfg ();

    battery_gauge_monitor dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    // gauge model state
    logic            m_chem;
    logic [15:0]     m_gain;
    logic [17:0]     m_mean;
    logic [2:0]      m_cells;
    bgm_pkg::color_t m_color;

    beat_t  pending_beats[$];
    gauge_t expected_gauge[$];
    int     errors = 0;
    int     src_idle_pct;
    int     snk_idle_pct;
    longint cycle_no = 0;

    function automatic logic [14:0] pack_of_mean();
        logic [63:0] p;
        p = (64'(m_mean) * 64'(m_gain)) >> 18;
        return (p > 64'd20000) ? 15'd20000 : p[14:0];
    endfunction

    function automatic int unsigned lookup_pct(int unsigned v);
        int unsigned pct;
        pct = 0;
        if (!m_chem) begin
            for (int i = 1; i < bgm_tb_pkg::LIPO_N; i++)
                if (v >= bgm_tb_pkg::LIPO_MV[i])
                begin
                    pct = bgm_tb_pkg::LIPO_PCT[i]
                          + ((bgm_tb_pkg::LIPO_PCT[i-1] - bgm_tb_pkg::LIPO_PCT[i])
                             * (v - bgm_tb_pkg::LIPO_MV[i]))
                          / (bgm_tb_pkg::LIPO_MV[i-1] - bgm_tb_pkg::LIPO_MV[i]);
                    break;
                end
        end
        else
        begin
            for (int i = 1; i < bgm_tb_pkg::LFP_N; i++)
                if (v >= bgm_tb_pkg::LFP_MV[i])
                begin
                    pct = bgm_tb_pkg::LFP_PCT[i]
                          + ((bgm_tb_pkg::LFP_PCT[i-1] - bgm_tb_pkg::LFP_PCT[i])
                             * (v - bgm_tb_pkg::LFP_MV[i]))
                          / (bgm_tb_pkg::LFP_MV[i-1] - bgm_tb_pkg::LFP_MV[i]);
                    break;
                end
        end
        return (pct > 99) ? 99 : pct;
    endfunction

    // Advances the gauge model by one beat and returns the expected reading.
    function automatic gauge_t gauge_step(beat_t b);
        gauge_t      g;
        logic [63:0] nm;
        logic [14:0] pk;
        int unsigned pct;
        if (!b.mode)
        begin
            if (m_mean == 0)
                m_mean = {b.adc, 8'd0};
            else
            begin
                nm = (64'(m_mean) * 64'd19 + 64'({b.adc, 8'd0})) / 64'd20;
                m_mean = nm[17:0];
            end
            pk = pack_of_mean();
            if (m_chem)              m_cells = 3'd1;
            else if (pk >= 15'd17000) m_cells = 3'd1;
            else if (pk >= 15'd12800) m_cells = 3'd4;
            else if (pk >= 15'd9000)  m_cells = 3'd3;
            else if (pk >= 15'd6000)  m_cells = 3'd2;
        end
        else
            m_color = bgm_pkg::color_t'(b.fcol);
        g.pack     = pack_of_mean();
        g.cells    = m_cells;
        g.per_cell = g.pack / ((m_cells == 0) ? 15'd1 : 15'(m_cells));
        pct        = lookup_pct(32'(g.per_cell));
        g.pct      = pct[6:0];
        if (!b.mode)
        begin
            if (pct >= 80 && m_color != bgm_pkg::COL_GREEN)
                m_color = bgm_pkg::COL_GREEN;
            else if (pct < 25 && m_color == bgm_pkg::COL_GREEN)
                m_color = bgm_pkg::COL_ORANGE;
            else if (pct < 15 && m_color == bgm_pkg::COL_ORANGE)
                m_color = bgm_pkg::COL_RED;
            else if (pct < 5 && m_color == bgm_pkg::COL_RED)
                m_color = bgm_pkg::COL_BLACK;
        end
        g.color = m_color;
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_no);
        errors++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Beat source: drives from the queue, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid        <= 1'b0;
            in_ch.mode         <= 1'b0;
            in_ch.adc_sample   <= '0;
            in_ch.forced_color <= '0;
        end
        else
        begin
            logic fire;
            fire = in_ch.valid && in_ch.ready;
            if (fire)
                expected_gauge.push_back(gauge_step({in_ch.mode, in_ch.adc_sample,
                                                     in_ch.forced_color}));
            if ((!in_ch.valid || fire) && pending_beats.size() > 0 &&
                $urandom_range(99, 0) >= src_idle_pct)
            begin
                beat_t b;
                b = pending_beats.pop_front();
                in_ch.valid        <= 1'b1;
                in_ch.mode         <= b.mode;
                in_ch.adc_sample   <= b.adc;
                in_ch.forced_color <= b.fcol;
            end
            else if (fire)
                in_ch.valid <= 1'b0;
        end
    end

    // Result sink: random stalls, compare against oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_gauge.size() == 0)
                    report_mismatch("unexpected reading", 1, 0);
                else
                begin
                    gauge_t w;
                    w = expected_gauge.pop_front();
                    if (out_ch.pack_mv !== w.pack)
                        report_mismatch("pack_mv", int'(out_ch.pack_mv), int'(w.pack));
                    if (out_ch.cells !== w.cells)
                        report_mismatch("cells", int'(out_ch.cells), int'(w.cells));
                    if (out_ch.per_cell_mv !== w.per_cell)
                        report_mismatch("per_cell_mv", int'(out_ch.per_cell_mv),
                                        int'(w.per_cell));
                    if (out_ch.charge_pct !== w.pct)
                        report_mismatch("charge_pct", int'(out_ch.charge_pct), int'(w.pct));
                    if (out_ch.color !== w.color)
                        report_mismatch("color", int'(out_ch.color), int'(w.color));
                end
            end
            out_ch.ready <= ($urandom_range(99, 0) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run as failed once cycle_no passes its limit.
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > 2000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() > 0 || in_ch.valid || expected_gauge.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == bgm_pkg::REG_CHEMISTRY) m_chem = val[0];
        else                               m_gain = val;
    endtask

    function automatic void push_beat(logic md, logic [9:0] a, logic [1:0] c);
        pending_beats.push_back({md, a, c});
    endfunction

    // Sweep: random walk from a random level with a downward drift, plus some forced-colour and random-level beats.
    function automatic void push_ramp(int n);
        int lvl;
        lvl = $urandom_range(1023, 0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9, 0) == 0)
                push_beat(1'b1, 10'($urandom), 2'($urandom));
            else
            begin
                lvl = lvl + $signed($urandom_range(80, 0)) - 44;
                if (lvl < 0) lvl = 0;
                if (lvl > 1023) lvl = 1023;
                if ($urandom_range(19, 0) == 0)
                    push_beat(1'b0, 10'($urandom), 2'($urandom));
                else
                    push_beat(1'b0, 10'(lvl), 2'($urandom));
            end
        end
    endfunction

    initial
    begin
        logic [15:0] gains [6];
        src_idle_pct = 18;
        snk_idle_pct = 56;
        m_chem  = 1'b0;
        m_gain  = bgm_pkg::GAIN_RESET;
        m_mean  = '0;
        m_cells = 3'd1;
        m_color = bgm_pkg::COL_GREEN;
        cfg.valid = 1'b0;
        cfg.index = bgm_pkg::REG_CHEMISTRY;
        cfg.data  = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero seed, extremes, forced colours, reseeding after decay
        push_beat(1'b1, 10'h3ff, 2'd3);
        push_beat(1'b0, 10'd0, 2'd0);
        push_beat(1'b0, 10'd1023, 2'd0);
        push_beat(1'b0, 10'd1023, 2'd3);
        for (int c = 0; c < 4; c++) push_beat(1'b1, 10'd0, 2'(c));
        push_beat(1'b0, 10'd0, 2'd0);
        for (int i = 0; i < 6; i++) push_beat(1'b0, 10'd210, 2'd0);
        for (int i = 0; i < 6; i++) push_beat(1'b0, 10'd150, 2'd0);
        push_beat(1'b0, 10'd700, 2'd1);
        push_beat(1'b0, 10'h155, 2'd2);
        push_beat(1'b0, 10'h2aa, 2'd1);
        wait_drained();

        gains = '{16'd0, 16'd65535, 16'd19955, 16'd8000, 16'd40000, 16'd30000};
        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 4)
            begin
                src_idle_pct = 56;
                snk_idle_pct = 18;
            end
            else if (ph == 8)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_reg(bgm_pkg::REG_CHEMISTRY, {15'd0, 1'(ph % 2)});
            write_reg(bgm_pkg::REG_GAIN, gains[ph % 6]);
            push_ramp(85);
            wait_drained();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
